### rtl/core/b5te_pkg.sv
// Shared types, constants and the symbol alphabet of the byte to 5-bit text encoder.
package b5te_pkg;

    // Symbols written on one line before a newline is inserted.
    localparam logic [6:0] LINE_CHARS   = 7'd72;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] CHAR_A       = 8'd65;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [4:0] ALPHA_LEN    = 5'd26;
    localparam logic [2:0] MAX_CARRY    = 3'd4;
    localparam int         MAX_CHARS    = 3;

    typedef enum logic
    {
        OP_DATA = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [3:0] carry_bits;
        logic [2:0] carry_count;
        logic [6:0] line_count;
        logic       seen_data;
    } enc_state_t;

    // Characters caused by one input word, first character in entry 0.
    typedef struct packed
    {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                count;
    } enc_result_t;

    function automatic logic [7:0] sym_to_char(input logic [4:0] v);
        logic [7:0] ch;
        if (v < ALPHA_LEN)
        begin
            ch = CHAR_A + {3'b000, v};
        end
        else
        begin
            ch = CHAR_ZERO + {3'b000, v - ALPHA_LEN};
        end
        return ch;
    endfunction

endpackage

### rtl/core/b5te_calc.sv
// Symbol split, alphabet mapping and line breaking for one input word.
module b5te_calc
    import b5te_pkg::*;
(
    input  enc_state_t  state,
    input  op_t         op,
    input  logic [7:0]  data_byte,
    output enc_result_t result,
    output enc_state_t  state_next
);

    always_comb
    begin
        logic [2:0]       cnt;
        logic [11:0]      acc;
        logic [1:0][4:0]  sym;
        logic [1:0]       nsym;
        logic [2:0]       left;
        logic [6:0]       lc;
        logic [1:0]       n;
        logic [8:0]       pad;

        cnt  = (state.carry_count > MAX_CARRY) ? MAX_CARRY : state.carry_count;
        acc  = {state.carry_bits, data_byte};
        sym  = '0;
        nsym = 2'd0;
        left = 3'd0;
        pad  = 9'({5'b00000, state.carry_bits} << (3'd5 - cnt));
        lc   = state.line_count;
        n    = 2'd0;
        result     = '0;
        state_next = state;

        case (op)
            OP_DATA:
            begin
                // First symbol takes the top five of the cnt+8 pending bits.
                sym[0] = 5'(acc >> (cnt + 3'd3));
                if (cnt >= 3'd2)
                begin
                    sym[1] = 5'(acc >> (cnt - 3'd2));
                    nsym   = 2'd2;
                    left   = cnt - 3'd2;
                end
                else
                begin
                    nsym = 2'd1;
                    left = cnt + 3'd3;
                end
            end
            OP_END:
            begin
                // Leftover bits are left-aligned and zero-filled.
                sym[0] = pad[4:0];
                nsym   = (cnt != 3'd0) ? 2'd1 : 2'd0;
            end
            default:
            begin
                nsym = 2'd0;
            end
        endcase

        for (int i = 0; i < 2; i++)
        begin
            if (2'(i) < nsym)
            begin
                result.chars[n] = sym_to_char(sym[i]);
                n  = n + 2'd1;
                lc = lc + 7'd1;
                if (lc >= LINE_CHARS)
                begin
                    result.chars[n] = NEWLINE_CHAR;
                    n  = n + 2'd1;
                    lc = 7'd0;
                end
            end
        end

        if (op == OP_END)
        begin
            if (state.seen_data && (lc != 7'd0))
            begin
                result.chars[n] = NEWLINE_CHAR;
                n = n + 2'd1;
            end
            state_next = '0;
        end
        else
        begin
            state_next.carry_bits  = 4'(data_byte & ((8'd1 << left) - 8'd1));
            state_next.carry_count = left;
            state_next.line_count  = lc;
            state_next.seen_data   = 1'b1;
        end

        result.count = n;
    end

endmodule

### rtl/core/b5te_emit.sv
// Result register that hands out the characters of one word, one per cycle while m_tready is high.
module b5te_emit
    import b5te_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  enc_result_t result,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tlast    // last
);

    logic                      valid_reg, valid_next;
    logic [1:0]                idx_reg, idx_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic [MAX_CHARS-1:0][7:0] chars_reg, chars_next;
    logic                      at_last;

    assign at_last  = (idx_reg == (cnt_reg - 2'd1));
    assign free     = !valid_reg || (m_tready && at_last);
    assign m_tvalid = valid_reg;
    assign m_tdata  = chars_reg[idx_reg];
    assign m_tlast  = at_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        chars_next = chars_reg;
        if (load)
        begin
            valid_next = (result.count != 2'd0);
            idx_next   = 2'd0;
            cnt_next   = result.count;
            chars_next = result.chars;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

### rtl/core/byte_to_5bit_text_encoder.sv
// Top level of the byte to 5-bit text encoder.
// Bytes are regrouped MSB first into 5-bit symbols written as 'A'-'Z' and '0'-'5',
// with a newline after every LINE_CHARS symbols; an end word (tuser = 1) flushes
// the leftover bits as one zero-padded symbol, closes a non-empty line and clears
// all state. Each input word is registered, turned into its up to three
// characters in a single step and moved to a result register that drives the
// output one character per cycle while m_tready is high, so the single output
// port limits the throughput; a word that yields no characters sends nothing.
// The next word is taken while the last character of the previous one is being
// handed out.
module byte_to_5bit_text_encoder
    import b5te_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // data_byte
    input  logic [0:0] s_tuser,    // op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_char
    output logic       m_tlast     // last
);

    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [7:0]  in_byte_reg;
    enc_state_t  state_reg, state_next;
    enc_result_t result;
    logic        free;
    logic        consume;

    assign consume  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || consume;

    b5te_calc u_calc
    (
        .state      (state_reg),
        .op         (in_op_reg),
        .data_byte  (in_byte_reg),
        .result     (result),
        .state_next (state_next)
    );

    b5te_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .result   (result),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= op_t'(s_tuser[0]);
            in_byte_reg <= s_tdata;
        end
    end

endmodule
